[rtl/core/irpd_pkg.sv]
`default_nettype none

package irpd_pkg;

	localparam int FRAME_BITS = 32;
	localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);
	localparam int INTERVAL_W = 16;
	localparam int LIMIT_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int BYTE_W     = 8;
	localparam int OUT_DATA_W = 40;

	localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST = 16'd1700;
	localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST  = 16'd3000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SHORT_LIMIT = 1'b0,
		CFG_LONG_LIMIT  = 1'b1
	} cfg_idx_t;

	localparam logic [BYTE_W-1:0] CMD_BOTH_OFF = 8'h98;
	localparam logic [BYTE_W-1:0] CMD_A_ONLY   = 8'hA2;
	localparam logic [BYTE_W-1:0] CMD_B_ONLY   = 8'h62;
	localparam logic [BYTE_W-1:0] CMD_BOTH_ON  = 8'hE2;

	localparam int NUM_TOGGLE = 11;
	localparam logic [BYTE_W-1:0] TOGGLE_CODES [NUM_TOGGLE] = '{
		8'h22, 8'h02, 8'hC2, 8'hE0, 8'hA8, 8'h90, 8'h10, 8'h5A, 8'h18, 8'h4A, 8'h38
	};

	// input register contents handed to the frame core
	typedef struct packed {
		logic                  valid;
		logic [INTERVAL_W-1:0] interval;
	} item_t;

	// led = {led_b, led_a}
	function automatic logic [1:0] led_update(input logic [BYTE_W-1:0] cmd,
						  input logic [1:0] led);
		logic [1:0] nxt;
		logic       hit;
		hit = 1'b0;
		for (int k = 0; k < NUM_TOGGLE; k++) begin
			if (cmd == TOGGLE_CODES[k]) begin
				hit = 1'b1;
			end
		end
		case (cmd)
			CMD_BOTH_OFF: nxt = 2'b00;
			CMD_A_ONLY:   nxt = 2'b01;
			CMD_B_ONLY:   nxt = 2'b10;
			CMD_BOTH_ON:  nxt = 2'b11;
			default:      nxt = hit ? ~led : led;
		endcase
		return nxt;
	endfunction

endpackage

`default_nettype wire

[rtl/core/irpd_in_stage.sv]
`default_nettype none

module irpd_in_stage (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [irpd_pkg::INTERVAL_W-1:0]  s_tdata,   // [15:0] interval
	input  wire logic                             take,
	output irpd_pkg::item_t                       item
);

	logic                            valid_s1;
	logic [irpd_pkg::INTERVAL_W-1:0] interval_s1;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			interval_s1 <= s_tdata;
		end
	end

	assign item = '{valid: valid_s1, interval: interval_s1};

endmodule

`default_nettype wire

[rtl/core/irpd_frame_core.sv]
`default_nettype none

module irpd_frame_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [irpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire irpd_pkg::item_t                  item,
	output logic                                  take,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [irpd_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tuser
);

	logic [irpd_pkg::LIMIT_W-1:0]    short_limit_q;
	logic [irpd_pkg::LIMIT_W-1:0]    long_limit_q;
	logic [irpd_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
	logic [irpd_pkg::FRAME_BITS-1:0] shift_q;
	logic [1:0]                      led_q;

	logic                            out_valid_q;
	logic                            done_q;
	logic [irpd_pkg::FRAME_BITS-1:0] frame_q;
	logic [1:0]                      led_out_q;

	logic                            is_zero;
	logic                            is_one;
	logic                            is_bit;
	logic [irpd_pkg::BIT_CNT_W-1:0]  cnt_inc;
	logic [irpd_pkg::FRAME_BITS-1:0] shift_nxt;
	logic                            done;
	logic [1:0]                      led_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_limit_q <= irpd_pkg::SHORT_LIMIT_RST;
			long_limit_q  <= irpd_pkg::LONG_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (irpd_pkg::cfg_idx_t'(cfg_addr))
				irpd_pkg::CFG_SHORT_LIMIT: short_limit_q <= cfg_wdata[irpd_pkg::LIMIT_W-1:0];
				irpd_pkg::CFG_LONG_LIMIT:  long_limit_q  <= cfg_wdata[irpd_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign take      = item.valid && (!out_valid_q || m_tready);
	assign is_zero   = item.interval < short_limit_q;
	assign is_one    = !is_zero && (item.interval < long_limit_q);
	assign is_bit    = is_zero || is_one;
	assign cnt_inc   = bit_cnt_q + irpd_pkg::BIT_CNT_W'(1);
	assign shift_nxt = {shift_q[irpd_pkg::FRAME_BITS-2:0], is_one};
	assign done      = is_bit && (cnt_inc == irpd_pkg::BIT_CNT_W'(irpd_pkg::FRAME_BITS));
	assign led_nxt   = done ? irpd_pkg::led_update(shift_nxt[15:8], led_q) : led_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q   <= '0;
			shift_q     <= '0;
			led_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				led_q       <= led_nxt;
				if (is_bit) begin
					shift_q   <= shift_nxt;
					bit_cnt_q <= done ? '0 : cnt_inc;
				end else begin
					bit_cnt_q <= '0;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			done_q    <= done;
			frame_q   <= done ? shift_nxt : '0;
			led_out_q <= led_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = done_q;
	assign m_tdata  = {6'b0, led_out_q[1], led_out_q[0],
			   frame_q[7:0], frame_q[15:8], frame_q[23:16], frame_q[31:24]};

	// the count wraps to zero on the frame's last bit, so it never reaches FRAME_BITS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q < irpd_pkg::BIT_CNT_W'(irpd_pkg::FRAME_BITS))
		else $error("bit count out of range");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && done |=> bit_cnt_q == '0 && done_q)
		else $error("bit count not cleared after frame");

	a_led_hold: assert property (@(posedge clk) disable iff (!arst_n)
		take && !done |=> $stable(led_q) && led_out_q == led_q)
		else $error("leds changed without a frame");

	a_idle_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !done_q |-> frame_q == '0)
		else $error("frame bytes nonzero without frame_done");

endmodule

`default_nettype wire

[rtl/core/ir_pulse_distance_frame_decoder_unit.sv]
// channel | dir | signals                      | content
// s       | in  | s_tvalid s_tready s_tdata    | IR falling-edge interval
// m       | out | m_tvalid m_tready m_tdata    | frame bytes and LED states
//         |     | m_tuser                      | frame_done
// cfg     | in  | cfg_wr_en cfg_addr cfg_wdata | 0 short_limit, 1 long_limit
//
// One item per cycle unless m stalls; an s transfer fills the input register,
// then classify/shift/LED decode into the result register raises m_tvalid.
// arst_n clears bit count, frame shift, LEDs, limits to 1700/3000 and both valids.
// A stalled m side holds the result; s_tready falls only once the input
// register is also full.
`default_nettype none

module ir_pulse_distance_frame_decoder_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [irpd_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [irpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [irpd_pkg::INTERVAL_W-1:0]  s_tdata,  // [15:0] interval
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// [7:0] address, [15:8] address_check, [23:16] command, [31:24] command_check,
	// [32] led_a, [33] led_b, [39:34] zero
	output logic [irpd_pkg::OUT_DATA_W-1:0]       m_tdata,
	output logic                                  m_tuser   // [0] frame_done
);

	irpd_pkg::item_t item;
	logic            take;

	irpd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (take),
		.item     (item)
	);

	irpd_frame_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.take      (take),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire
